// File: design/wmdf_pkg.sv
package wmdf_pkg;

    localparam int SAMPLE_W    = 17;
    localparam int MEAN_W      = 16;
    localparam int ADJ_W       = 18;
    localparam int HELD_W      = 5;
    localparam int OFFSET_W    = 8;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 40;

    // -80 in two's complement
    localparam logic [OFFSET_W-1:0] OFFSET_RESET = 8'hB0;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_WAIT
    } t_state;

endpackage

// File: design/windowed_mean_distance_filter_top.sv
// Running mean of the last WINDOW valid distance samples. A sample with bit 16
// set (negative, -1 = no reading) is not stored and just reports the current
// mean; tuser high empties the window. Samples sit in a shift chain of WINDOW
// cells, the last cell being the oldest one that leaves the sum once full.
// Each item runs through these steps: window and sum update on the accepting
// edge, a registered start loads the divider, the bit-serial divider (width
// SUM_W = 16 + clog2(WINDOW)) works out the quotient, then the result lands in
// the output register once that register is free. The input is ready again
// when the result is loaded, so no new item is taken while one is dividing.
// The next item is taken while a result still waits on the output side.
module windowed_mean_distance_filter_top #(
    parameter int WINDOW = 20
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // config: mount_offset_mm
    input  logic                                i_cfg_wen,
    input  logic [wmdf_pkg::OFFSET_W-1:0]       i_cfg_wdata,
    // [16:0] sample_mm, [23:17] zero
    input  logic [wmdf_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    // [0] clear_filter
    input  logic                                i_s_tuser,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // [15:0] mean_mm, [33:16] adjusted_mean_mm, [38:34] samples_held, [39] zero
    output logic [wmdf_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready
);
    import wmdf_pkg::*;

    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int SUM_W = MEAN_W + $clog2(WINDOW);

    t_state r_state;
    t_state n_state;

    logic [OFFSET_W-1:0] r_offset;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic [SUM_W-1:0]    r_sum;
    logic [SUM_W-1:0]    n_sum;
    logic                r_start;

    logic                r_out_valid;
    logic [MEAN_W-1:0]   r_mean;
    logic [ADJ_W-1:0]    r_adj;
    logic [HELD_W-1:0]   r_held;

    logic                w_in_acc;
    logic                w_sample_ok;
    logic                w_shift;
    logic                w_full;
    logic                w_out_free;
    logic                w_load;
    logic                w_div_done;
    logic [SUM_W-1:0]    w_quot;
    logic [MEAN_W-1:0]   w_mean;
    logic [MEAN_W-1:0]   w_tap [WINDOW+1];

    assign w_in_acc    = i_s_tvalid && o_s_tready;
    assign w_sample_ok = !i_s_tdata[SAMPLE_W-1];
    assign w_shift     = w_in_acc && !i_s_tuser && w_sample_ok;
    assign w_full      = (r_count == CNT_W'(WINDOW));
    assign w_out_free  = !r_out_valid || i_m_tready;

    // window storage: new sample enters cell 0, oldest sits in the last cell
    assign w_tap[0] = i_s_tdata[MEAN_W-1:0];

    for (genvar g = 0; g < WINDOW; g++) begin : g_cell
        wmdf_cell u_cell (
            .i_clk  (i_clk),
            .i_shift(w_shift),
            .i_data (w_tap[g]),
            .o_data (w_tap[g+1])
        );
    end

    always_comb begin
        n_count = r_count;
        n_sum   = r_sum;
        if (w_in_acc && i_s_tuser) begin
            n_count = '0;
            n_sum   = '0;
        end else if (w_shift) begin
            n_count = w_full ? r_count : r_count + 1'b1;
            n_sum   = r_sum - (w_full ? SUM_W'(w_tap[WINDOW]) : '0)
                      + SUM_W'(i_s_tdata[MEAN_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_sum    <= '0;
            r_offset <= OFFSET_RESET;
            r_start  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_sum   <= n_sum;
            r_start <= w_in_acc;
            if (i_cfg_wen) begin
                r_offset <= i_cfg_wdata;
            end
        end
    end

    wmdf_div #(
        .SUM_W(SUM_W),
        .CNT_W(CNT_W)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_start),
        .i_dividend(r_sum),
        .i_divisor (r_count),
        .o_done    (w_div_done),
        .o_quotient(w_quot)
    );

    // divide by zero gives all ones; empty window reports 0
    assign w_mean = (r_count == '0) ? '0 : w_quot[MEAN_W-1:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) n_state = S_DIV;
            end
            S_DIV: begin
                if (w_div_done) n_state = w_out_free ? S_IDLE : S_WAIT;
            end
            S_WAIT: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready = 1'b0;
        w_load     = 1'b0;
        unique case (r_state)
            S_IDLE:  o_s_tready = 1'b1;
            S_DIV:   w_load     = w_div_done && w_out_free;
            S_WAIT:  w_load     = w_out_free;
            default: w_load     = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_mean <= w_mean;
            r_adj  <= ADJ_W'(w_mean) + ADJ_W'($signed(r_offset));
            r_held <= HELD_W'(r_count);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_held, r_adj, r_mean};

endmodule

// File: design/wmdf_cell.sv
module wmdf_cell (
    input  logic                       i_clk,
    input  logic                       i_shift,
    input  logic [wmdf_pkg::MEAN_W-1:0] i_data,
    output logic [wmdf_pkg::MEAN_W-1:0] o_data
);
    import wmdf_pkg::*;

    logic [MEAN_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_data <= i_data;
        end
    end

    assign o_data = r_data;

endmodule

// File: design/wmdf_div.sv
module wmdf_div #(
    parameter int SUM_W = 21,
    parameter int CNT_W = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [SUM_W-1:0] i_dividend,
    input  logic [CNT_W-1:0] i_divisor,
    output logic             o_done,
    output logic [SUM_W-1:0] o_quotient
);
    localparam int ITER_W = $clog2(SUM_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [ITER_W-1:0] r_iter;
    logic [CNT_W-1:0]  r_rem;
    logic [SUM_W-1:0]  r_quot;

    logic [CNT_W:0]    w_trial;
    logic [CNT_W:0]    w_diff;
    logic              w_fits;

    // restoring divide, one quotient bit per cycle, dividend shifts out the top
    assign w_trial = {r_rem, r_quot[SUM_W-1]};
    assign w_fits  = (w_trial >= {1'b0, i_divisor});
    assign w_diff  = w_trial - {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_iter <= ITER_W'(SUM_W);
        end else if (r_busy) begin
            r_iter <= r_iter - 1'b1;
            r_done <= (r_iter == ITER_W'(1));
            r_busy <= (r_iter != ITER_W'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quot <= i_dividend;
        end else if (r_busy) begin
            r_rem  <= w_fits ? w_diff[CNT_W-1:0] : w_trial[CNT_W-1:0];
            r_quot <= {r_quot[SUM_W-2:0], w_fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quot;

endmodule

// File: design/wmdf_checker.sv
module wmdf_checker #(
    parameter int WINDOW = 20
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_tvalid,
    input logic                             o_s_tready,
    input logic [wmdf_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    input logic                             o_m_tvalid,
    input logic                             i_m_tready
);
    import wmdf_pkg::*;

    // one item in flight at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input taken while an item is in flight");

    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (32'(o_m_tdata[38:34]) <= WINDOW))
        else $error("samples_held above window size");

    a_empty_mean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tdata[38:34] == '0)) |-> (o_m_tdata[15:0] == '0))
        else $error("nonzero mean with empty window");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result changed");

endmodule

bind windowed_mean_distance_filter_top wmdf_checker #(
    .WINDOW(WINDOW)
) u_wmdf_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_s_tvalid(i_s_tvalid),
    .o_s_tready(o_s_tready),
    .o_m_tdata (o_m_tdata),
    .o_m_tvalid(o_m_tvalid),
    .i_m_tready(i_m_tready)
);

// File: dv/windowed_mean_distance_filter_top_test.sv
class mean_scoreboard;
    localparam int WINDOW = 20;

    typedef struct {
        logic [15:0] mean;
        logic [17:0] adjusted;
        logic [4:0]  held;
    } t_mean_result;

    bit [15:0]         window_ring [WINDOW];
    bit [4:0]          next_slot;
    bit [4:0]          held_count;
    bit [20:0]         window_sum;
    logic signed [7:0] offset_mm;
    t_mean_result      expected_means [$];
    int                errors;
    int                items_seen;
    int                clears_seen;
    int                invalid_seen;
    int                means_checked;

    function new();
        offset_mm = wmdf_pkg::OFFSET_RESET;
    endfunction

    function void set_offset(logic [7:0] value);
        offset_mm = value;
    endfunction

    function int pending();
        return expected_means.size();
    endfunction

    // Accepted input item: update window state, queue the mean it yields.
    function void note_sample(logic [16:0] sample, logic clr);
        t_mean_result r;
        int           adj;
        items_seen++;
        if (clr) begin
            clears_seen++;
            next_slot = '0;
            held_count = '0;
            window_sum = '0;
        end else if (sample[16]) begin
            invalid_seen++;
        end else begin
            if (held_count < WINDOW) begin
                held_count++;
            end else begin
                window_sum -= window_ring[next_slot];
            end
            window_ring[next_slot] = sample[15:0];
            window_sum += sample[15:0];
            next_slot = (next_slot == WINDOW - 1) ? 5'd0 : next_slot + 5'd1;
        end
        r.mean = (held_count == 0) ? 16'd0 : 16'(window_sum / held_count);
        adj = int'(r.mean) + int'(offset_mm);
        r.adjusted = adj[17:0];
        r.held = held_count;
        expected_means.push_back(r);
    endfunction

    function void check_result(logic [39:0] tdata);
        t_mean_result r;
        if (expected_means.size() == 0) begin
            $error("result with no item pending: tdata %h", tdata);
            errors++;
            return;
        end
        r = expected_means.pop_front();
        means_checked++;
        if (tdata[15:0] !== r.mean) begin
            $error("mean_mm: expected %0d, got %0d", r.mean, tdata[15:0]);
            errors++;
        end
        if (tdata[33:16] !== r.adjusted) begin
            $error("adjusted_mean_mm: expected %0d, got %0d",
                   $signed(r.adjusted), $signed(tdata[33:16]));
            errors++;
        end
        if (tdata[38:34] !== r.held) begin
            $error("samples_held: expected %0d, got %0d", r.held, tdata[38:34]);
            errors++;
        end
    endfunction
endclass

module windowed_mean_distance_filter_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import wmdf_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 30;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_wen = 1'b0;
    logic [OFFSET_W-1:0]    i_cfg_wdata = '0;
    // [16:0] sample_mm, [23:17] zero
    logic [IN_TDATA_W-1:0]  i_s_tdata = '0;
    // [0] clear_filter
    logic                   i_s_tuser = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    // [15:0] mean_mm, [33:16] adjusted_mean_mm, [38:34] samples_held, [39] zero
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;

    mean_scoreboard sb = new();
    bit             steady_tail = 1'b0;
    int             cycles = 0;

    windowed_mean_distance_filter_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // results first: a result leaving at this edge belongs to an older item
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                sb.check_result(o_m_tdata);
            end
            if (i_s_tvalid && o_s_tready) begin
                sb.note_sample(i_s_tdata[SAMPLE_W-1:0], i_s_tuser);
            end
        end
    end

    // receiver: random stall bursts, none in the tail
    initial begin
        @(posedge i_clk);
        forever begin
            if (!steady_tail && $urandom_range(0, 2) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge i_clk);
        end
    end

    task automatic send_sample(input logic [SAMPLE_W-1:0] sample, input logic clr);
        if (!steady_tail && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_s_tdata <= {{(IN_TDATA_W - SAMPLE_W){1'b0}}, sample};
        i_s_tuser <= clr;
        i_s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // only with the filter drained
    task automatic write_offset(input logic [OFFSET_W-1:0] value);
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        i_cfg_wen <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_wen <= 1'b0;
        sb.set_offset(value);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int kind;
        kind = $urandom_range(0, 99);
        if (kind < 6) return 17'h1FFFF;
        if (kind < 10) return {1'b1, 16'($urandom)};
        if (kind < 16) return 17'h0FFFF;
        if (kind < 20) return 17'h00000;
        if (kind < 55) return 17'($urandom_range(0, 3000));
        return {1'b0, 16'($urandom)};
    endfunction

    task automatic run_random(input int count, input int quiet_from);
        logic clr;
        for (int i = 0; i < count; i++) begin
            if (i >= quiet_from) steady_tail = 1'b1;
            clr = ($urandom_range(0, 49) == 0);
            send_sample(pick_sample(), clr);
        end
        i_s_tvalid <= 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset offset; empty window, invalid on empty, extremes, clear, full-scale wrap
        send_sample(17'h1FFFF, 1'b0);
        send_sample(17'h00000, 1'b0);
        send_sample(17'h0FFFF, 1'b0);
        send_sample(17'h10000, 1'b0);
        send_sample(17'h0FFFF, 1'b1);
        for (int i = 0; i < 21; i++) send_sample(17'h0FFFF, 1'b0);
        i_s_tvalid <= 1'b0;

        write_offset(8'h7F);
        run_random(300, 300);
        write_offset(8'h80);
        run_random(300, 300);
        write_offset(8'd0);
        run_random(300, 300);
        write_offset(8'($urandom_range(0, 255)));
        run_random(300, 300);
        write_offset(8'($urandom_range(0, 255)));
        run_random(250, 100);

        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d items (%0d clears, %0d invalid samples), %0d means checked",
                 sb.items_seen, sb.clears_seen, sb.invalid_seen, sb.means_checked);
        $display("Offsets -80, 127, -128, 0 and two random; full-scale window wrap included");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
